// ===== sv/snc_pkg.sv =====
// Package for the sliding normalised correlation block.
// Sizes and reset values shared by the block; no dependencies.
`timescale 1ns / 1ps
package snc_pkg;
    localparam int MAX_TEMPLATE = 256;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_W       = 8;
    localparam int LEN_W        = 9;
    localparam logic [LEN_W-1:0] LEN_RESET = 9'd64;
    localparam logic [LEN_W-1:0] LEN_MIN   = 9'd2;
    localparam logic [LEN_W-1:0] LEN_MAX   = 9'd256;
    localparam int WIDE_W       = 132;
endpackage

// ===== sv/sliding_normalized_correlation.sv =====
// Sliding normalised cross-correlation of a sample stream against a stored template.
// Depends on snc_pkg.
`timescale 1ns / 1ps
// Template beats (tuser 0) load the template one sample a cycle while the block is idle and restart the window.
// Signal beats (tuser 1) enter a 256-entry ring; once L samples are held (L is
// template_len clamped to 2..256), every signal beat yields one Pearson coefficient in
// Q1.15, or a no_variance flag when template or window is flat. A template beat, or a
// signal beat that yields no result, leaves the block idle for the next beat. A signal beat
// that yields a result keeps the input stalled through the multiply-accumulate pass over the
// two memories (one read port each), eight products on a shared 64 x 8 bit multiplier, the
// bit-by-bit coefficient search and the hand-over of the result to the output register. A
// flat template or window ends after four products. A finished result waits in the output
// register while the next beat is accepted; the input is also held off in any cycle with
// cfg_wen high.
module sliding_normalized_correlation
    import snc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [8:0]  cfg_wdata,    // template_len
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] sample
    input  logic        s_tuser,      // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [15:0] correlation, [31:16] window_index
    output logic        m_tuser       // no_variance
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_MLOAD = 3'd2;
    localparam logic [2:0] ST_MRUN  = 3'd3;
    localparam logic [2:0] ST_MDONE = 3'd4;
    localparam logic [2:0] ST_STRY  = 3'd5;
    localparam logic [2:0] ST_SCMP  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    logic [15:0] tmem [0:MAX_TEMPLATE-1];
    logic [15:0] wmem [0:MAX_TEMPLATE-1];

    logic [2:0]        state_reg;
    logic [LEN_W-1:0]  tlen_reg, load_ptr_reg, fill_reg, issue_reg;
    logic [ADDR_W-1:0] ring_ptr_reg, ridx_reg;
    logic [15:0]       wcnt_reg, widx_reg;
    logic              rd_vld_reg, pr_vld_reg;
    logic signed [15:0] t_rdata_reg, w_rdata_reg, x_reg, y_reg;
    logic [31:0]        xx_reg, yy_reg;
    logic signed [31:0] xy_reg;
    logic signed [24:0] sx_reg, sy_reg;
    logic [40:0]        sxx_reg, syy_reg;
    logic signed [40:0] sxy_reg;
    logic [2:0]         step_reg, mcnt_reg;
    logic [63:0]        ma_reg, mb_reg, a_reg, b_reg;
    logic [127:0]       acc_reg, ab_reg;
    logic signed [63:0] tmp_reg, n_reg;
    logic               novar_reg;
    logic [WIDE_W-1:0]  msq_reg, p_reg, qs_reg, abs_reg, t_reg;
    logic [15:0]        c_reg;
    logic [3:0]         sk_reg;
    logic               m_vld_reg, m_novar_reg;
    logic [15:0]        m_corr_reg, m_widx_reg;

    logic [LEN_W-1:0] len;
    logic             accept;
    logic [LEN_W-1:0] lp, lp_inc, fill_next;
    logic [63:0]      op_a, op_b;
    logic [71:0]      mpart, mtop;
    logic signed [63:0] prod_s;
    logic [63:0]      b_new;
    logic [15:0]      corr;

    always_comb begin
        if (tlen_reg < LEN_MIN) begin
            len = LEN_MIN;
        end else if (tlen_reg > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = tlen_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_wen;
    assign accept   = s_tvalid && s_tready;
    assign lp       = (load_ptr_reg >= len) ? '0 : load_ptr_reg;
    assign lp_inc   = lp + 9'd1;
    assign fill_next = (fill_reg < len) ? fill_reg + 9'd1 : fill_reg;

    always_comb begin
        unique case (step_reg)
            3'd0: begin op_a = 64'(len); op_b = 64'(sxx_reg); end
            3'd1: begin op_a = mag64(64'(sx_reg)); op_b = mag64(64'(sx_reg)); end
            3'd2: begin op_a = 64'(len); op_b = 64'(syy_reg); end
            3'd3: begin op_a = mag64(64'(sy_reg)); op_b = mag64(64'(sy_reg)); end
            3'd4: begin op_a = 64'(len); op_b = mag64(64'(sxy_reg)); end
            3'd5: begin op_a = mag64(64'(sx_reg)); op_b = mag64(64'(sy_reg)); end
            3'd6: begin op_a = a_reg; op_b = b_reg; end
            default: begin op_a = mag64(n_reg); op_b = mag64(n_reg); end
        endcase
    end

    // Radix-256 shift-and-add: the product settles in acc_reg after eight steps.
    assign mpart = 72'(ma_reg) * 72'(mb_reg[7:0]);
    assign mtop  = 72'(acc_reg[127:64]) + mpart;
    assign prod_s = $signed(acc_reg[63:0]);
    assign b_new = tmp_reg - acc_reg[63:0];

    always_comb begin
        if (novar_reg) begin
            corr = '0;
        end else if (n_reg[63]) begin
            corr = ~c_reg + 16'd1;
        end else if (c_reg[15]) begin
            corr = 16'h7FFF;
        end else begin
            corr = c_reg;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (accept && !s_tuser) begin
            tmem[lp[ADDR_W-1:0]] <= s_tdata;
        end
        if (accept && s_tuser) begin
            wmem[ring_ptr_reg] <= s_tdata;
        end
        t_rdata_reg <= $signed(tmem[issue_reg[ADDR_W-1:0]]);
        w_rdata_reg <= $signed(wmem[ridx_reg]);
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        x_reg  <= t_rdata_reg;
        y_reg  <= w_rdata_reg;
        xx_reg <= 32'(t_rdata_reg * t_rdata_reg);
        yy_reg <= 32'(w_rdata_reg * w_rdata_reg);
        xy_reg <= t_rdata_reg * w_rdata_reg;
        if (accept) begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            widx_reg <= wcnt_reg;
        end else if (pr_vld_reg) begin
            sx_reg  <= sx_reg + 25'(x_reg);
            sy_reg  <= sy_reg + 25'(y_reg);
            sxx_reg <= sxx_reg + 41'(xx_reg);
            syy_reg <= syy_reg + 41'(yy_reg);
            sxy_reg <= sxy_reg + 41'(xy_reg);
        end
        if (state_reg == ST_MLOAD) begin
            ma_reg  <= op_a;
            mb_reg  <= op_b;
            acc_reg <= '0;
        end else if (state_reg == ST_MRUN) begin
            acc_reg <= {mtop, acc_reg[63:8]};
            mb_reg  <= mb_reg >> 8;
        end
        if (state_reg == ST_MDONE) begin
            unique case (step_reg)
                3'd0: tmp_reg <= prod_s;
                3'd1: a_reg <= tmp_reg - acc_reg[63:0];
                3'd2: tmp_reg <= prod_s;
                3'd3: b_reg <= b_new;
                3'd4: tmp_reg <= sxy_reg[40] ? -prod_s : prod_s;
                3'd5: n_reg <= tmp_reg - ((sx_reg[24] != sy_reg[24]) ? -prod_s : prod_s);
                3'd6: ab_reg <= acc_reg;
                default: begin
                    msq_reg <= WIDE_W'(acc_reg) << 30;
                    p_reg   <= '0;
                    qs_reg  <= '0;
                    abs_reg <= WIDE_W'(ab_reg) << 30;
                    c_reg   <= '0;
                    sk_reg  <= 4'd15;
                end
            endcase
        end
        if (state_reg == ST_STRY) begin
            t_reg <= p_reg + qs_reg + abs_reg;
        end
        // Trial bit k: (c + 2^k)^2 AB = P + (cAB << k+1) + (AB << 2k), kept pre-shifted.
        if (state_reg == ST_SCMP) begin
            if (t_reg <= msq_reg) begin
                p_reg  <= t_reg;
                c_reg  <= c_reg | (16'd1 << sk_reg);
                qs_reg <= (qs_reg + (abs_reg << 1)) >> 1;
            end else begin
                qs_reg <= qs_reg >> 1;
            end
            abs_reg <= abs_reg >> 2;
            sk_reg  <= sk_reg - 4'd1;
        end
        if ((state_reg == ST_OUT) && (!m_vld_reg || m_tready)) begin
            m_corr_reg  <= corr;
            m_novar_reg <= novar_reg;
            m_widx_reg  <= widx_reg;
        end
    end

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tlen_reg     <= LEN_RESET;
            load_ptr_reg <= '0;
            fill_reg     <= '0;
            ring_ptr_reg <= '0;
            wcnt_reg     <= '0;
            issue_reg    <= '0;
            ridx_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            pr_vld_reg   <= 1'b0;
            step_reg     <= '0;
            mcnt_reg     <= '0;
            novar_reg    <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == ST_MAC) && (issue_reg < len);
            pr_vld_reg <= rd_vld_reg;
            if ((state_reg == ST_OUT) && (!m_vld_reg || m_tready)) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
            if (cfg_wen) begin
                tlen_reg     <= cfg_wdata;
                load_ptr_reg <= '0;
                fill_reg     <= '0;
                ring_ptr_reg <= '0;
                wcnt_reg     <= '0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && !s_tuser) begin
                        load_ptr_reg <= (lp_inc >= len) ? '0 : lp_inc;
                        fill_reg     <= '0;
                        ring_ptr_reg <= '0;
                        wcnt_reg     <= '0;
                    end else if (accept) begin
                        ring_ptr_reg <= ring_ptr_reg + 8'd1;
                        fill_reg     <= fill_next;
                        if (fill_next >= len) begin
                            // Oldest sample of the window sits L - 1 places behind the sample just written.
                            ridx_reg  <= ring_ptr_reg + 8'd1 - len[ADDR_W-1:0];
                            issue_reg <= '0;
                            wcnt_reg  <= wcnt_reg + 16'd1;
                            novar_reg <= 1'b0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_MAC: begin
                    if (issue_reg < len) begin
                        issue_reg <= issue_reg + 9'd1;
                        ridx_reg  <= ridx_reg + 8'd1;
                    end else if (!rd_vld_reg && !pr_vld_reg) begin
                        step_reg  <= '0;
                        state_reg <= ST_MLOAD;
                    end
                end
                ST_MLOAD: begin
                    mcnt_reg  <= '0;
                    state_reg <= ST_MRUN;
                end
                ST_MRUN: begin
                    mcnt_reg <= mcnt_reg + 3'd1;
                    if (mcnt_reg == 3'd7) begin
                        state_reg <= ST_MDONE;
                    end
                end
                ST_MDONE: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7) begin
                        state_reg <= ST_STRY;
                    end else if ((step_reg == 3'd3) && ((a_reg == '0) || (b_new == '0))) begin
                        novar_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MLOAD;
                    end
                end
                ST_STRY: begin
                    state_reg <= ST_SCMP;
                end
                ST_SCMP: begin
                    state_reg <= (sk_reg == 4'd0) ? ST_OUT : ST_STRY;
                end
                default: begin
                    if (!m_vld_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {m_widx_reg, m_corr_reg};
    assign m_tuser  = m_novar_reg;

endmodule
